@@ rtl/core/hbs_pkg.sv @@
// shared constants, codes and types of the heightmap bilinear sampler
`default_nettype none

package hbs_pkg;

  // grid geometry
  localparam int GRID_SEGS_MAX   = 63;
  localparam int SEG_W           = 6;
  localparam int ROW_W           = SEG_W + 1;
  localparam int ADDR_W          = 12;
  localparam int GRID_DEPTH      = 1 << ADDR_W;

  // coordinates and samples
  localparam int COORD_W         = 18;
  localparam int COORD_FRAC_BITS = 16;
  localparam int CLAMP_W         = COORD_FRAC_BITS + 1;
  localparam int PROD_W          = CLAMP_W + SEG_W;
  localparam int FRAC_W          = 16;
  localparam int H_W             = 16;
  localparam int OUT_W           = 32;

  // configuration port
  localparam int CFG_IDX_W       = 1;
  localparam int CFG_W           = SEG_W;
  localparam logic [CFG_IDX_W-1:0] REG_SEG_X = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SEG_Z = 1'd1;

  // word kinds
  localparam logic MODE_WRITE = 1'b0;
  localparam logic MODE_QUERY = 1'b1;

  // the four corner taps of a cell
  localparam int NUM_TAPS = 4;
  localparam int TAP_11   = 0;
  localparam int TAP_21   = 1;
  localparam int TAP_12   = 2;
  localparam int TAP_22   = 3;

  typedef struct packed {
    logic                               wr;
    logic [ADDR_W-1:0]                  waddr;
    logic [H_W-1:0]                     wdata;
    logic [NUM_TAPS-1:0][ADDR_W-1:0]    raddr;
  } hbs_mem_req_t;

endpackage

`default_nettype wire

@@ rtl/core/hbs_if.sv @@
// channel interfaces of the heightmap bilinear sampler
`default_nettype none

interface hbs_in_if import hbs_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic                      mode;
  logic [ADDR_W-1:0]         grid_index;
  logic signed [H_W-1:0]     sample_height;
  logic signed [COORD_W-1:0] x_pos;
  logic signed [COORD_W-1:0] z_pos;

  modport source (output valid, mode, grid_index, sample_height, x_pos, z_pos,
                  input ready);
  modport sink (input valid, mode, grid_index, sample_height, x_pos, z_pos,
                output ready);
endinterface

interface hbs_out_if import hbs_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [OUT_W-1:0] height_out;

  modport source (output valid, height_out, input ready);
  modport sink (input valid, height_out, output ready);
endinterface

`default_nettype wire

@@ rtl/core/heightmap_bilinear_sampler_unit.sv @@
// top level of the heightmap bilinear sampler: seven-stage lerp pipeline
// a query word's height leaves from the stage 7 register once the word has passed every stage
// throughput: one word per cycle unless result.ready stalls the pipe, writes and queries mixed in any order
// a write lands in the grid store at the fourth stage, in order with queries
// reset clears the stage valid bits and sets both segment counts to 1
// the grid store is not cleared; the user must write an entry before it is read, the block does not enforce it
`default_nettype none

module heightmap_bilinear_sampler_unit import hbs_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  hbs_in_if.sink               item_in,
  hbs_out_if.source            result
);

  // configuration
  logic [SEG_W-1:0] seg_x;
  logic [SEG_W-1:0] seg_z;
  logic [SEG_W-1:0] sx;
  logic [SEG_W-1:0] sz;

  always_ff @(posedge clk) begin
    if (rst) begin
      seg_x <= SEG_W'(1);
      seg_z <= SEG_W'(1);
    end else if (cfg_we) begin
      case (cfg_index)
        REG_SEG_X: seg_x <= cfg_data;
        REG_SEG_Z: seg_z <= cfg_data;
        default: ;
      endcase
    end
  end

  // a zero count acts as one, large counts saturate
  always_comb begin
    sx = seg_x;
    sz = seg_z;
    if (seg_x == '0) sx = SEG_W'(1);
    else if (seg_x > SEG_W'(GRID_SEGS_MAX)) sx = SEG_W'(GRID_SEGS_MAX);
    if (seg_z == '0) sz = SEG_W'(1);
    else if (seg_z > SEG_W'(GRID_SEGS_MAX)) sz = SEG_W'(GRID_SEGS_MAX);
  end

  // stage advance: a stage moves when empty or when the next one moves
  logic v1, v2, v3, v4, v5, v6, v7;
  logic adv1, adv2, adv3, adv4, adv5, adv6, adv7;

  assign adv7 = !v7 || result.ready;
  assign adv6 = !v6 || adv7;
  assign adv5 = !v5 || adv6;
  assign adv4 = !v4 || adv5;
  assign adv3 = !v3 || adv4;
  assign adv2 = !v2 || adv3;
  assign adv1 = !v1 || adv2;
  assign item_in.ready = adv1;

  // stage 1: clamp both coordinates to the plate
  localparam logic [COORD_W-1:0] COORD_ONE = COORD_W'(1) << COORD_FRAC_BITS;

  logic               mode1;
  logic [ADDR_W-1:0]  gidx1;
  logic [H_W-1:0]     samp1;
  logic [CLAMP_W-1:0] cx1, cz1;
  logic [CLAMP_W-1:0] cx_next, cz_next;

  always_comb begin
    if (item_in.x_pos[COORD_W-1]) cx_next = '0;
    else if (item_in.x_pos > COORD_ONE) cx_next = CLAMP_W'(COORD_ONE);
    else cx_next = item_in.x_pos[CLAMP_W-1:0];
    if (item_in.z_pos[COORD_W-1]) cz_next = '0;
    else if (item_in.z_pos > COORD_ONE) cz_next = CLAMP_W'(COORD_ONE);
    else cz_next = item_in.z_pos[CLAMP_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (adv1) begin
      v1 <= item_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv1) begin
      mode1 <= item_in.mode;
      gidx1 <= item_in.grid_index;
      samp1 <= item_in.sample_height;
      cx1   <= cx_next;
      cz1   <= cz_next;
    end
  end

  // stage 2: scale by the segment count into cell index and fraction
  logic              mode2;
  logic [ADDR_W-1:0] gidx2;
  logic [H_W-1:0]    samp2;
  logic [SEG_W-1:0]  cell_x2, cell_z2;
  logic [FRAC_W-1:0] fx2, fz2;
  logic [PROD_W-1:0] px, pz;

  assign px = PROD_W'(cx1) * PROD_W'(sx);
  assign pz = PROD_W'(cz1) * PROD_W'(sz);

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (adv2) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (adv2) begin
      mode2   <= mode1;
      gidx2   <= gidx1;
      samp2   <= samp1;
      cell_x2 <= px[COORD_FRAC_BITS +: SEG_W];
      cell_z2 <= pz[COORD_FRAC_BITS +: SEG_W];
      fx2     <= px[COORD_FRAC_BITS-1 -: FRAC_W];
      fz2     <= pz[COORD_FRAC_BITS-1 -: FRAC_W];
    end
  end

  // stage 3: neighbour clamp and the four corner addresses
  logic                            mode3;
  logic [ADDR_W-1:0]               gidx3;
  logic [H_W-1:0]                  samp3;
  logic [FRAC_W-1:0]               fx3, fz3;
  logic [NUM_TAPS-1:0][ADDR_W-1:0] addr3;
  logic [SEG_W-1:0]                nx, nz;
  logic [ROW_W-1:0]                row_w;
  logic [ADDR_W-1:0]               row_lo, row_hi;
  logic [NUM_TAPS-1:0][ADDR_W-1:0] addr_next;

  always_comb begin
    nx = (ROW_W'(cell_x2) + ROW_W'(1) > ROW_W'(sx)) ? sx : cell_x2 + SEG_W'(1);
    nz = (ROW_W'(cell_z2) + ROW_W'(1) > ROW_W'(sz)) ? sz : cell_z2 + SEG_W'(1);
    row_w  = ROW_W'(sx) + ROW_W'(1);
    row_lo = ADDR_W'(cell_z2) * ADDR_W'(row_w);
    row_hi = ADDR_W'(nz) * ADDR_W'(row_w);
    addr_next[TAP_11] = row_lo + ADDR_W'(cell_x2);
    addr_next[TAP_21] = row_lo + ADDR_W'(nx);
    addr_next[TAP_12] = row_hi + ADDR_W'(cell_x2);
    addr_next[TAP_22] = row_hi + ADDR_W'(nx);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (adv3) begin
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (adv3) begin
      mode3 <= mode2;
      gidx3 <= gidx2;
      samp3 <= samp2;
      fx3   <= fx2;
      fz3   <= fz2;
      addr3 <= addr_next;
    end
  end

  // stage 4: grid store access; writes end here, queries read four corners
  hbs_mem_req_t                  mem_req;
  logic [NUM_TAPS-1:0][H_W-1:0]  corner;
  logic [FRAC_W-1:0]             fx4, fz4;

  always_comb begin
    mem_req.wr    = v3 && (mode3 == MODE_WRITE);
    mem_req.waddr = gidx3;
    mem_req.wdata = samp3;
    mem_req.raddr = addr3;
  end

  hbs_grid_mem u_grid (
    .clk   (clk),
    .en    (adv4),
    .req   (mem_req),
    .rdata (corner)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
    end else if (adv4) begin
      v4 <= v3 && (mode3 == MODE_QUERY);
    end
  end

  always_ff @(posedge clk) begin
    if (adv4) begin
      fx4 <= fx3;
      fz4 <= fz3;
    end
  end

  // stage 5: the two lerps along x, exact in q16.16
  logic signed [H_W:0]         d_lo, d_hi;
  logic signed [2*H_W+1:0]     m_lo, m_hi, base_lo, base_hi, a_full, b_full;
  logic signed [OUT_W-1:0]     a5, b5;
  logic [FRAC_W-1:0]           fz5;
  logic [H_W-1:0]              h11, h21, h12, h22;

  always_comb begin
    h11 = corner[TAP_11];
    h21 = corner[TAP_21];
    h12 = corner[TAP_12];
    h22 = corner[TAP_22];
    d_lo = $signed({h21[H_W-1], h21}) - $signed({h11[H_W-1], h11});
    d_hi = $signed({h22[H_W-1], h22}) - $signed({h12[H_W-1], h12});
    m_lo = d_lo * $signed({1'b0, fx4});
    m_hi = d_hi * $signed({1'b0, fx4});
    base_lo = $signed({{2{h11[H_W-1]}}, h11, {FRAC_W{1'b0}}});
    base_hi = $signed({{2{h12[H_W-1]}}, h12, {FRAC_W{1'b0}}});
    a_full = base_lo + m_lo;
    b_full = base_hi + m_hi;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v5 <= 1'b0;
    end else if (adv5) begin
      v5 <= v4;
    end
  end

  always_ff @(posedge clk) begin
    if (adv5) begin
      a5  <= a_full[OUT_W-1:0];
      b5  <= b_full[OUT_W-1:0];
      fz5 <= fz4;
    end
  end

  // stage 6: weight the row difference by the z fraction
  logic signed [OUT_W:0]          diff;
  logic signed [OUT_W+FRAC_W+1:0] prod_next, prod6;
  logic signed [OUT_W-1:0]        a6;

  always_comb begin
    diff      = $signed({b5[OUT_W-1], b5}) - $signed({a5[OUT_W-1], a5});
    prod_next = diff * $signed({1'b0, fz5});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v6 <= 1'b0;
    end else if (adv6) begin
      v6 <= v5;
    end
  end

  always_ff @(posedge clk) begin
    if (adv6) begin
      a6    <= a5;
      prod6 <= prod_next;
    end
  end

  // stage 7: arithmetic shift by 16 and final add, held as the output word
  logic signed [OUT_W-1:0] r7;

  always_ff @(posedge clk) begin
    if (rst) begin
      v7 <= 1'b0;
    end else if (adv7) begin
      v7 <= v6;
    end
  end

  always_ff @(posedge clk) begin
    if (adv7) begin
      r7 <= a6 + prod6[FRAC_W +: OUT_W];
    end
  end

  assign result.valid      = v7;
  assign result.height_out = r7;

endmodule

`default_nettype wire

@@ rtl/core/hbs_grid_mem.sv @@
// height grid store, one copy per corner tap, shared write
`default_nettype none

module hbs_grid_mem import hbs_pkg::*; (
  input  logic                           clk,
  input  logic                           en,
  input  hbs_mem_req_t                   req,
  output logic [NUM_TAPS-1:0][H_W-1:0]   rdata
);

  logic [H_W-1:0] grid [NUM_TAPS][GRID_DEPTH];

  always_ff @(posedge clk) begin
    if (en) begin
      for (int t = 0; t < NUM_TAPS; t++) begin
        rdata[t] <= grid[t][req.raddr[t]];
        if (req.wr) begin
          grid[t][req.waddr] <= req.wdata;
        end
      end
    end
  end

endmodule

`default_nettype wire

@@ test/heightmap_bilinear_sampler_unit_test.sv @@
// self-checking testbench of the heightmap bilinear sampler unit
`timescale 1ns / 1ps

module heightmap_bilinear_sampler_unit_test;
  import hbs_pkg::*;

  // run bounds, drain slack and stimulus sizes
  localparam int unsigned CYCLE_LIMIT     = 500000;
  localparam int          DRAIN_SLACK     = 12;
  localparam int          HOLD_OFF_CYCLES = 200;
  localparam int          WORDS_PER_PHASE = 250;
  localparam int          NUM_PHASES      = 8;
  localparam longint      PLATE_ONE       = longint'(1) << COORD_FRAC_BITS;

  // one input word plus an optional hand-typed height for directed rows
  typedef struct packed {
    logic                      mode;
    logic [ADDR_W-1:0]         grid_index;
    logic signed [H_W-1:0]     sample_height;
    logic signed [COORD_W-1:0] x_pos;
    logic signed [COORD_W-1:0] z_pos;
    logic                      typed;
    logic [OUT_W-1:0]          height;
  } heightmap_word_t;

  // receiver stall patterns
  typedef enum int {RX_ALWAYS, RX_RANDOM, RX_PERIODIC} rx_style_t;

  logic                 clk = 1'b0;
  logic                 rst;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_data;

  hbs_in_if  item_ch ();
  hbs_out_if result_ch ();

  heightmap_bilinear_sampler_unit dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .item_in   (item_ch),
    .result    (result_ch)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // own copy of the grid store and of the segment registers
  logic signed [H_W-1:0] grid_model [GRID_DEPTH];
  bit                    grid_written [GRID_DEPTH];
  logic [CFG_W-1:0]      seg_x_model;
  logic [CFG_W-1:0]      seg_z_model;

  // heights still owed by the block, oldest first
  logic [OUT_W-1:0] expected_heights [$];
  logic [OUT_W-1:0] next_height;

  int unsigned cycle_count   = 0;
  int unsigned fail_count    = 0;
  int unsigned query_count   = 0;
  int unsigned write_count   = 0;
  int unsigned height_count  = 0;
  int unsigned setting_count = 0;

  // sender burst control and receiver hold-off request
  bit        gaps_on;
  bit        hold_off_req;
  int        burst_left;
  rx_style_t rx_style;
  int        rx_tick;
  int        hold_left;

  // segment settings walked by the random phases; the last two are random
  logic [CFG_W-1:0] phase_seg_x [6] = '{6'd0, 6'd63, 6'd63, 6'd1, 6'd0, 6'd17};
  logic [CFG_W-1:0] phase_seg_z [6] = '{6'd0, 6'd63, 6'd1, 6'd63, 6'd40, 6'd5};

  // directed rows, all at the reset setting of one segment each way (entries 0..3)
  heightmap_word_t directed_rows [18] = '{
    // load the four corners with the two sample extremes, zero and -1; coords are don't-care
    '{MODE_WRITE, 12'd0,   16'h8000, 18'h3FFFF, 18'h20000, 1'b0, 32'h0},
    '{MODE_WRITE, 12'd1,   16'h7FFF, 18'h1FFFF, 18'h00000, 1'b0, 32'h0},
    '{MODE_WRITE, 12'd2,   16'h0000, 18'h15555, 18'h2AAAA, 1'b0, 32'h0},
    '{MODE_WRITE, 12'd3,   16'hFFFF, 18'h00000, 18'h1FFFF, 1'b0, 32'h0},
    // corner hits read straight off the grid
    '{MODE_QUERY, 12'hFFF, 16'h7FFF, 18'h00000, 18'h00000, 1'b1, 32'h8000_0000},
    '{MODE_QUERY, 12'h000, 16'h0000, 18'h10000, 18'h00000, 1'b1, 32'h7FFF_0000},
    // coordinates far outside the plate clamp to its edges
    '{MODE_QUERY, 12'h000, 16'h0000, 18'h20000, 18'h1FFFF, 1'b1, 32'h0000_0000},
    '{MODE_QUERY, 12'h000, 16'h0000, 18'h1FFFF, 18'h1FFFF, 1'b1, 32'hFFFF_0000},
    // interior points with full-swing deltas, and one point clamped to the plate edge
    '{MODE_QUERY, 12'h000, 16'h0000, 18'h08000, 18'h00000, 1'b0, 32'h0},
    '{MODE_QUERY, 12'h000, 16'h0000, 18'h08000, 18'h08000, 1'b0, 32'h0},
    '{MODE_QUERY, 12'h000, 16'h0000, 18'h0FFFF, 18'h0FFFF, 1'b0, 32'h0},
    '{MODE_QUERY, 12'h000, 16'h0000, 18'h3FFFF, 18'h10000, 1'b1, 32'h0000_0000},
    // write at the top of the store, outside the active grid
    '{MODE_WRITE, 12'hFFF, 16'h5A5A, 18'h2AAAA, 18'h15555, 1'b0, 32'h0},
    // query fields grid_index and sample_height must be ignored
    '{MODE_QUERY, 12'hFFF, 16'h8000, 18'h00001, 18'h00001, 1'b0, 32'h0},
    // overwrite a corner then read it back
    '{MODE_WRITE, 12'd0,   16'h1234, 18'h00000, 18'h00000, 1'b0, 32'h0},
    '{MODE_QUERY, 12'h000, 16'h0000, 18'h00000, 18'h00000, 1'b1, 32'h1234_0000},
    '{MODE_QUERY, 12'h000, 16'h0000, 18'h1FFFF, 18'h20000, 1'b1, 32'h7FFF_0000},
    '{MODE_QUERY, 12'h000, 16'h0000, 18'h0C000, 18'h04000, 1'b0, 32'h0}
  };

  // zero counts act as one, large counts saturate
  function automatic int unsigned eff_segs(input logic [CFG_W-1:0] s);
    if (s == 0) return 1;
    if (s > GRID_SEGS_MAX) return GRID_SEGS_MAX;
    return 32'(s);
  endfunction

  // clamp to the plate, scale by the segment count, split into cell and fraction
  function automatic void split_coord(input logic signed [COORD_W-1:0] c,
                                      input int unsigned segs,
                                      output int unsigned cell_idx,
                                      output logic [FRAC_W-1:0] frac);
    longint          clamped;
    longint unsigned prod;
    clamped = c;
    if (clamped < 0) clamped = 0;
    if (clamped > PLATE_ONE) clamped = PLATE_ONE;
    prod = clamped * segs;
    cell_idx = 32'(prod >> COORD_FRAC_BITS);
    frac = FRAC_W'(((prod & (PLATE_ONE - 1)) << FRAC_W) >> COORD_FRAC_BITS);
  endfunction

  // grid addresses of the four corners and the two fractions of a query point
  function automatic void locate_cell(input logic signed [COORD_W-1:0] x,
                                      input logic signed [COORD_W-1:0] z,
                                      output logic [NUM_TAPS-1:0][ADDR_W-1:0] taps,
                                      output logic [FRAC_W-1:0] fx,
                                      output logic [FRAC_W-1:0] fz);
    int unsigned sx, sz, ix, iz, ix2, iz2, row_len;
    sx = eff_segs(seg_x_model);
    sz = eff_segs(seg_z_model);
    split_coord(x, sx, ix, fx);
    split_coord(z, sz, iz, fz);
    // neighbour clamped at the far edge
    ix2 = (ix + 1 > sx) ? sx : ix + 1;
    iz2 = (iz + 1 > sz) ? sz : iz + 1;
    row_len = sx + 1;
    // truncation to the address width wraps modulo the store depth
    taps[TAP_11] = ADDR_W'(iz * row_len + ix);
    taps[TAP_21] = ADDR_W'(iz * row_len + ix2);
    taps[TAP_12] = ADDR_W'(iz2 * row_len + ix);
    taps[TAP_22] = ADDR_W'(iz2 * row_len + ix2);
  endfunction

  // two lerps along x, one along z, floor shift back to Q16.16
  function automatic logic [OUT_W-1:0] predict_height(input logic signed [COORD_W-1:0] x,
                                                      input logic signed [COORD_W-1:0] z);
    logic [NUM_TAPS-1:0][ADDR_W-1:0] taps;
    logic [FRAC_W-1:0]               fx, fz;
    longint                          h11, h21, h12, h22, lfx, lfz, a, b, r;
    locate_cell(x, z, taps, fx, fz);
    h11 = grid_model[taps[TAP_11]];
    h21 = grid_model[taps[TAP_21]];
    h12 = grid_model[taps[TAP_12]];
    h22 = grid_model[taps[TAP_22]];
    lfx = fx;
    lfz = fz;
    a = h11 * 65536 + (h21 - h11) * lfx;
    b = h12 * 65536 + (h22 - h12) * lfx;
    r = a + (((b - a) * lfz) >>> 16);
    return r[OUT_W-1:0];
  endfunction

  function automatic heightmap_word_t random_word(input logic mode);
    heightmap_word_t w;
    w.mode          = mode;
    w.grid_index    = ADDR_W'($urandom());
    w.sample_height = H_W'($urandom());
    w.x_pos         = COORD_W'($urandom());
    w.z_pos         = COORD_W'($urandom());
    w.typed         = 1'b0;
    w.height        = '0;
    return w;
  endfunction

  // mostly on the plate, often on cell boundaries, sometimes far off it
  function automatic logic signed [COORD_W-1:0] random_coord(input logic [CFG_W-1:0] seg);
    int unsigned s, k, pick;
    s = eff_segs(seg);
    pick = $urandom_range(0, 99);
    if (pick < 55) return COORD_W'($urandom_range(0, 65536));
    if (pick < 75) begin
      k = $urandom_range(0, s);
      return COORD_W'((65536 * k) / s + $urandom_range(0, 2) - 1);
    end
    if (pick < 85) return COORD_W'(-$urandom_range(1, 131072));
    return COORD_W'($urandom());
  endfunction

  // offer one word in bursts with random gaps, predict once it is taken
  task automatic send_word(input heightmap_word_t w);
    int               gap;
    logic [OUT_W-1:0] owed;
    @(negedge clk);
    if (gaps_on && burst_left == 0) begin
      gap = $urandom_range(1, 6);
      item_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
      burst_left = $urandom_range(1, 20);
    end
    item_ch.valid         <= 1'b1;
    item_ch.mode          <= w.mode;
    item_ch.grid_index    <= w.grid_index;
    item_ch.sample_height <= w.sample_height;
    item_ch.x_pos         <= w.x_pos;
    item_ch.z_pos         <= w.z_pos;
    do @(posedge clk); while (!item_ch.ready);
    if (burst_left > 0) burst_left--;
    if (w.mode == MODE_WRITE) begin
      grid_model[w.grid_index]   = w.sample_height;
      grid_written[w.grid_index] = 1'b1;
      write_count++;
    end else begin
      owed = w.typed ? w.height : predict_height(w.x_pos, w.z_pos);
      expected_heights = {expected_heights, owed};
      query_count++;
    end
  endtask

  // a query is only sent once every corner it touches holds a sample
  task automatic send_query(input logic signed [COORD_W-1:0] x,
                            input logic signed [COORD_W-1:0] z);
    logic [NUM_TAPS-1:0][ADDR_W-1:0] taps;
    logic [FRAC_W-1:0]               fx, fz;
    heightmap_word_t                 w;
    locate_cell(x, z, taps, fx, fz);
    for (int t = 0; t < NUM_TAPS; t++) begin
      if (!grid_written[taps[t]]) begin
        w = random_word(MODE_WRITE);
        w.grid_index = taps[t];
        send_word(w);
      end
    end
    w = random_word(MODE_QUERY);
    w.x_pos = x;
    w.z_pos = z;
    send_word(w);
  endtask

  // stop offering, wait for every owed height, then let trailing writes land
  task automatic wait_for_heights();
    @(negedge clk);
    item_ch.valid <= 1'b0;
    while (expected_heights.size() != 0) @(posedge clk);
    repeat (DRAIN_SLACK) @(posedge clk);
  endtask

  // drains the pipeline first, then writes both segment registers
  task automatic set_segments(input logic [CFG_W-1:0] sx, input logic [CFG_W-1:0] sz);
    wait_for_heights();
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= REG_SEG_X;
    cfg_data  <= sx;
    @(negedge clk);
    cfg_index <= REG_SEG_Z;
    cfg_data  <= sz;
    @(negedge clk);
    cfg_we    <= 1'b0;
    @(posedge clk);
    seg_x_model = sx;
    seg_z_model = sz;
    setting_count++;
  endtask

  // receiver: picks a new stall pattern at intervals, honours hold-off
  initial begin
    result_ch.ready = 1'b0;
    rx_style  = RX_ALWAYS;
    rx_tick   = 0;
    hold_left = 0;
    forever begin
      @(negedge clk);
      rx_tick++;
      if (rx_tick % 300 == 0) rx_style = rx_style_t'($urandom_range(0, 2));
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        hold_left    = HOLD_OFF_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        result_ch.ready <= 1'b0;
      end else begin
        case (rx_style)
          RX_ALWAYS: result_ch.ready <= 1'b1;
          RX_RANDOM: result_ch.ready <= ($urandom_range(0, 99) >= 35);
          default:   result_ch.ready <= ((rx_tick % 7) > 1);
        endcase
      end
    end
  end

  // result checker: every taken word must match the oldest owed height
  always @(posedge clk) begin
    if (!rst && result_ch.valid && result_ch.ready) begin
      if (expected_heights.size() == 0) begin
        fail_count++;
        $display("%0t: unexpected height word %h, nothing owed", $time,
                 result_ch.height_out);
      end else begin
        next_height = expected_heights.pop_front();
        height_count++;
        if (result_ch.height_out !== next_height) begin
          fail_count++;
          $display("%0t: height mismatch: expected %h, actual %h", $time,
                   next_height, result_ch.height_out);
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("heightmap_bilinear_sampler_unit test failed");
      $finish;
    end
  end

  // main stimulus
  initial begin
    heightmap_word_t w;
    int unsigned     phase_start;
    bit              paused;
    rst                   = 1'b1;
    cfg_we                = 1'b0;
    cfg_index             = REG_SEG_X;
    cfg_data              = '0;
    item_ch.valid         = 1'b0;
    item_ch.mode          = MODE_WRITE;
    item_ch.grid_index    = '0;
    item_ch.sample_height = '0;
    item_ch.x_pos         = '0;
    item_ch.z_pos         = '0;
    gaps_on               = 1'b1;
    hold_off_req          = 1'b0;
    burst_left            = 0;
    // reset state of the registers
    seg_x_model           = 6'd1;
    seg_z_model           = 6'd1;
    setting_count         = 1;

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed corner, clamp and ignored-field cases
    foreach (directed_rows[i]) send_word(directed_rows[i]);

    for (int p = 0; p < NUM_PHASES; p++) begin
      if (p < 6) set_segments(phase_seg_x[p], phase_seg_z[p]);
      else set_segments(CFG_W'($urandom_range(0, 63)), CFG_W'($urandom_range(0, 63)));
      // every third phase runs with no sender gaps at all
      gaps_on = (p % 3) != 2;
      if (p == 1) begin
        // long receiver hold-off against a steady sender to back up the pipe
        gaps_on      = 1'b0;
        hold_off_req = 1'b1;
      end
      // each phase sends at least WORDS_PER_PHASE words, corner fills included
      phase_start = write_count + query_count;
      paused      = 1'b0;
      while (write_count + query_count - phase_start < WORDS_PER_PHASE) begin
        if (p == 3 && !paused &&
            write_count + query_count - phase_start >= WORDS_PER_PHASE / 2) begin
          wait_for_heights();
          paused = 1'b1;
        end
        if ($urandom_range(0, 99) < 25) begin
          w = random_word(MODE_WRITE);
          // mostly rewrite the active grid so queries see changing samples
          if ($urandom_range(0, 9) < 7)
            w.grid_index = ADDR_W'($urandom_range(0, (eff_segs(seg_x_model) + 1) *
                                                     (eff_segs(seg_z_model) + 1) - 1));
          send_word(w);
        end else begin
          send_query(random_coord(seg_x_model), random_coord(seg_z_model));
        end
      end
    end

    wait_for_heights();
    repeat (DRAIN_SLACK) @(posedge clk);

    $display("covered %0d grid writes and %0d height queries (%0d heights checked)",
             write_count, query_count, height_count);
    $display("over %0d segment settings, with sender gaps, receiver stalls and hold-off",
             setting_count);
    if (fail_count == 0) begin
      $display("heightmap_bilinear_sampler_unit test passed");
    end else begin
      $display("heightmap_bilinear_sampler_unit test failed");
    end
    $finish;
  end

endmodule
